FILE: rtl/core/coverage_span_alpha_blender_defines.svh
// Assertion macros for the coverage span alpha blender.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef COVERAGE_SPAN_ALPHA_BLENDER_DEFINES_SVH
`define COVERAGE_SPAN_ALPHA_BLENDER_DEFINES_SVH
`ifndef SYNTHESIS
`define CSAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CSAB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CSAB_ASSERT(lbl, prop, msg)
`define CSAB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/core/csab_pkg.sv
// Shared types and constants of the coverage span alpha blender.
// No dependencies; imported by every module of the block.
`default_nettype none

package csab_pkg;

  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned RampAw    = 8;
  localparam int unsigned RampDw    = 9;
  localparam int unsigned RampAccW  = 25;
  localparam int unsigned RampStepW = 17;

  localparam logic [CfgIdxW-1:0] CFG_COLOR_RED   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_GREEN = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_BLUE  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_ALPHA = 8'd3;

  localparam logic [7:0]  OPAQUE_ALPHA   = 8'hff;
  localparam logic [15:0] FULL_COVERAGE  = 16'd255;
  localparam logic [16:0] RAMP_SCALE     = 17'd66051;
  localparam logic [7:0]  RAMP_ROUND     = 8'h80;
  localparam logic [RampAccW-1:0] RAMP_ACC_INIT = 25'h0008000;

  typedef struct packed {
    logic [31:0]        dest_pixel;
    logic signed [31:0] coverage_delta;
    logic               line_start;
    logic [31:0]        start_coverage;
    logic               line_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        line_end_out;
  } out_item_t;

  // Ramp builder to ramp memory: write port plus busy flag.
  typedef struct packed {
    logic              busy;
    logic              wr_en;
    logic [RampAw-1:0] wr_addr;
    logic [RampDw-1:0] wr_data;
  } ramp_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/coverage_span_alpha_blender.sv
// Coverage span alpha blender top level: coverage accumulate, ramp lookup,
// blend and output register. Depends on csab_pkg, csab_ramp_gen,
// csab_ramp_mem, csab_blend and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------
//   in      | input     | in_valid / stall   | in_item_t  dest pixel
//   out     | output    | out_valid / stall  | out_item_t blended pixel
//   cfg     | input     | cfg_we, no wait    | index + 8-bit data
//
// One pixel per cycle unless a stalled output or a ramp rebuild holds the
// input; a result passes the ramp memory read and the output register.
// After reset and after every write of color_alpha the ramp is rebuilt, a
// setup step and then one entry per cycle, and no input transfer is taken
// meanwhile. A stalled output holds the pipeline.
`default_nettype none
`include "coverage_span_alpha_blender_defines.svh"

module coverage_span_alpha_blender import csab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic        alpha_we;
  ramp_ctl_t   ramp_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      alpha_q <= OPAQUE_ALPHA;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_RED:   red_q   <= cfg_wdata_i;
        CFG_COLOR_GREEN: green_q <= cfg_wdata_i;
        CFG_COLOR_BLUE:  blue_q  <= cfg_wdata_i;
        CFG_COLOR_ALPHA: alpha_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign alpha_we = cfg_we_i && (cfg_idx_i == CFG_COLOR_ALPHA);

  csab_ramp_gen u_ramp_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alpha_we),
    .alpha_i (alpha_q),
    .ctl_o   (ramp_ctl)
  );

  // Pipeline control
  logic out_valid_q, s1_valid_q;
  logic out_ready, s1_free, in_acc;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_ready;
  assign in_stall_o = ramp_ctl.busy || !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Coverage accumulate
  logic [31:0] cov_sum_q, cov_base, cov_sum_d;
  logic        opaque, idx_zero, idx_full;

  assign cov_base  = in_data_i.line_start ? in_data_i.start_coverage : cov_sum_q;
  assign cov_sum_d = cov_base + unsigned'(in_data_i.coverage_delta);
  assign opaque    = (alpha_q == OPAQUE_ALPHA);
  assign idx_zero  = opaque ? (cov_sum_d[31:16] == '0) : (cov_sum_d[23:16] == '0);
  assign idx_full  = opaque && (cov_sum_d[31:16] >= FULL_COVERAGE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_sum_q <= '0;
    end else if (in_acc) begin
      cov_sum_q <= cov_sum_d;
    end
  end

  logic [RampDw-1:0] ramp_rd;

  csab_ramp_mem u_ramp_mem (
    .clk_i     (clk_i),
    .ctl_i     (ramp_ctl),
    .rd_en_i   (in_acc),
    .rd_addr_i (cov_sum_d[16 +: RampAw]),
    .rd_data_o (ramp_rd)
  );

  // Stage 1: ramp value arrives, blend
  logic [31:0] s1_pix_q;
  logic        s1_pass_q, s1_full_q, s1_line_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (out_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= in_data_i.dest_pixel;
      s1_pass_q     <= idx_zero;
      s1_full_q     <= idx_full;
      s1_line_end_q <= in_data_i.line_end;
    end
  end

  logic [31:0] blend_pix, s1_result;

  csab_blend u_blend (
    .pix_i   (s1_pix_q),
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .alpha_i (ramp_rd),
    .pix_o   (blend_pix)
  );

  always_comb begin
    if (s1_pass_q) begin
      s1_result = s1_pix_q;
    end else if (s1_full_q) begin
      s1_result = {OPAQUE_ALPHA, blue_q, green_q, red_q};
    end else begin
      s1_result = blend_pix;
    end
  end

  // Output register
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_data_q.pixel_out    <= s1_result;
      out_data_q.line_end_out <= s1_line_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CSAB_ASSERT(a_no_read_during_sweep, !(ramp_ctl.wr_en && in_acc), "ramp read during sweep")
  `CSAB_ASSERT_NEXT(a_alpha_write_blocks, alpha_we, in_stall_o, "item taken after alpha write")
  `CSAB_ASSERT_NEXT(a_transfer_fills_s1, in_acc, s1_valid_q, "transfer lost in stage 1")

endmodule

`default_nettype wire

FILE: rtl/core/csab_ramp_gen.sv
// Opacity ramp builder: sweeps all ramp entries after reset and after
// every opacity write. Depends on csab_pkg.
`default_nettype none

module csab_ramp_gen import csab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] alpha_i,
  output ramp_ctl_t  ctl_o
);

  typedef enum logic [1:0] {
    RG_IDLE,
    RG_PREP,
    RG_SWEEP
  } rg_state_e;

  rg_state_e             state_q;
  logic [RampAw-1:0]     cnt_q;
  logic [RampAccW-1:0]   acc_q;
  logic [RampStepW-1:0]  step_q;
  logic [RampAccW-1:0]   step_prod;

  assign step_prod = RampAccW'(alpha_i) * RampAccW'(RAMP_SCALE) + RampAccW'(RAMP_ROUND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RG_PREP;
      cnt_q   <= '0;
      acc_q   <= RAMP_ACC_INIT;
      step_q  <= '0;
    end else if (start_i) begin
      state_q <= RG_PREP;
    end else begin
      case (state_q)
        RG_PREP: begin
          step_q  <= step_prod[RampAccW-1:8];
          acc_q   <= RAMP_ACC_INIT;
          cnt_q   <= '0;
          state_q <= RG_SWEEP;
        end
        RG_SWEEP: begin
          acc_q <= acc_q + RampAccW'(step_q);
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) begin
            state_q <= RG_IDLE;
          end
        end
        default: begin
          state_q <= RG_IDLE;
        end
      endcase
    end
  end

  assign ctl_o.busy    = (state_q != RG_IDLE);
  assign ctl_o.wr_en   = (state_q == RG_SWEEP);
  assign ctl_o.wr_addr = cnt_q;
  assign ctl_o.wr_data = acc_q[RampAccW-1:16];

endmodule

`default_nettype wire

FILE: rtl/core/csab_ramp_mem.sv
// Opacity ramp memory, 256 x 9, one write and one registered read port.
// Depends on csab_pkg.
`default_nettype none

module csab_ramp_mem import csab_pkg::*; (
  input  logic              clk_i,
  input  ramp_ctl_t         ctl_i,
  input  logic              rd_en_i,
  input  logic [RampAw-1:0] rd_addr_i,
  output logic [RampDw-1:0] rd_data_o
);

  logic [RampDw-1:0] mem_q [2**RampAw];
  logic [RampDw-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/csab_blend.sv
// Per-channel rounded blend of a destination pixel toward the paint color and ramp value.
// Depends on csab_pkg.
`default_nettype none

module csab_blend import csab_pkg::*; (
  input  logic [31:0]       pix_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [RampDw-1:0] alpha_i,
  output logic [31:0]       pix_o
);

  logic [3:0][RampDw-1:0] target;

  // Fourth channel blends toward the ramp value itself.
  assign target = {alpha_i, {1'b0, blue_i}, {1'b0, green_i}, {1'b0, red_i}};

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    logic signed [19:0] rnd;

    always_comb begin
      diff = signed'({1'b0, target[l]}) - signed'({2'b00, pix_i[8*l +: 8]});
      prod = 20'(diff) * 20'(signed'({1'b0, alpha_i}));
      rnd  = (prod + 20'sd128) >>> 8;
    end

    assign pix_o[8*l +: 8] = pix_i[8*l +: 8] + rnd[7:0];
  end

endmodule

`default_nettype wire

FILE: sim/coverage_span_alpha_blender_test.sv
// Self-checking bench for the coverage span alpha blender: spans of pixels with
// random coverage deltas under several paint settings, checked against a scoreboard.
// Depends on csab_pkg and the coverage_span_alpha_blender top level only.

class span_blend_scoreboard;
  logic [7:0]          paint_red;
  logic [7:0]          paint_green;
  logic [7:0]          paint_blue;
  logic [7:0]          paint_alpha;
  logic [31:0]         running_coverage;
  logic [8:0]          opacity_ramp[256];
  csab_pkg::out_item_t expected_pixels[$];
  int unsigned         mismatches;
  int unsigned         pixels_checked;

  function new();
    paint_red        = '0;
    paint_green      = '0;
    paint_blue       = '0;
    paint_alpha      = csab_pkg::OPAQUE_ALPHA;
    running_coverage = '0;
    mismatches       = 0;
    pixels_checked   = 0;
    rebuild_ramp(csab_pkg::OPAQUE_ALPHA);
  endfunction

  function void rebuild_ramp(logic [7:0] opacity);
    logic [31:0] acc;
    logic [31:0] step;
    acc  = 32'(csab_pkg::RAMP_ACC_INIT);
    step = (32'(opacity) * 32'(csab_pkg::RAMP_SCALE) + 32'(csab_pkg::RAMP_ROUND)) >> 8;
    for (int i = 0; i < 256; i++) begin
      opacity_ramp[i] = acc[24:16];
      acc += step;
    end
  endfunction

  function void write_reg(logic [csab_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
    case (idx)
      csab_pkg::CFG_COLOR_RED:   paint_red = val;
      csab_pkg::CFG_COLOR_GREEN: paint_green = val;
      csab_pkg::CFG_COLOR_BLUE:  paint_blue = val;
      csab_pkg::CFG_COLOR_ALPHA: begin
        paint_alpha = val;
        rebuild_ramp(val);
      end
      default: ;
    endcase
  endfunction

  // Move v toward c by weight a/256 with rounding; the arithmetic shift floors.
  function logic [7:0] blend_channel(int v, int c, int a);
    int t;
    t = (c - v) * a + 128;
    return 8'(v + (t >>> 8));
  endfunction

  function void predict_pixel(csab_pkg::in_item_t it);
    logic [31:0]         sum;
    logic [15:0]         idx;
    int                  a;
    csab_pkg::out_item_t want;
    sum = (it.line_start ? it.start_coverage : running_coverage) + it.coverage_delta;
    running_coverage = sum;
    idx = sum[31:16];
    if (paint_alpha != csab_pkg::OPAQUE_ALPHA) idx[15:8] = '0;
    want.pixel_out    = it.dest_pixel;
    want.line_end_out = it.line_end;
    if (idx != 0) begin
      if (paint_alpha == csab_pkg::OPAQUE_ALPHA && idx >= csab_pkg::FULL_COVERAGE) begin
        want.pixel_out = {csab_pkg::OPAQUE_ALPHA, paint_blue, paint_green, paint_red};
      end else begin
        a = opacity_ramp[idx[7:0]];
        want.pixel_out = {blend_channel(it.dest_pixel[31:24], a, a),
                          blend_channel(it.dest_pixel[23:16], paint_blue, a),
                          blend_channel(it.dest_pixel[15:8], paint_green, a),
                          blend_channel(it.dest_pixel[7:0], paint_red, a)};
      end
    end
    expected_pixels.push_back(want);
  endfunction

  function void check_pixel(csab_pkg::out_item_t got);
    csab_pkg::out_item_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: pixel %h line_end %b arrived with nothing pending", $time,
               got.pixel_out, got.line_end_out);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    pixels_checked++;
    if (got.pixel_out !== want.pixel_out) begin
      $display("%0t: pixel_out expected %h actual %h", $time, want.pixel_out, got.pixel_out);
      mismatches++;
    end
    if (got.line_end_out !== want.line_end_out) begin
      $display("%0t: line_end_out expected %b actual %b", $time, want.line_end_out,
               got.line_end_out);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction
endclass

module coverage_span_alpha_blender_test;
  import csab_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 96;
  localparam int unsigned SettleCycles  = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxPastEnd = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxTop     = 8'hff;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]         cfg_wdata_i;

  span_blend_scoreboard blend_sb;
  int unsigned          in_transfers;
  int unsigned          cfg_writes;
  int unsigned          idle_cycles;
  int unsigned          burst_left;
  bit                   hold_off_req;

  coverage_span_alpha_blender dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Transfers, register writes and the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        blend_sb.write_reg(cfg_idx_i, cfg_wdata_i);
        cfg_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        blend_sb.predict_pixel(in_data_i);
        in_transfers++;
      end
      if (out_valid_o && !out_stall_i) blend_sb.check_pixel(out_data_o);
      if (cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern; a hold-off request stalls for a long fixed stretch.
  initial begin
    int unsigned mode;
    int unsigned len;
    forever begin
      if (hold_off_req) begin
        repeat (HoldOffCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 30);
        repeat (len) begin
          @(negedge clk_i);
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            2:       out_stall_i <= ($urandom_range(0, 3) == 0);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  function automatic in_item_t mk_item(logic [31:0] dest, logic [31:0] start,
                                       logic [31:0] delta, logic ls, logic le);
    in_item_t it;
    it.dest_pixel     = dest;
    it.coverage_delta = delta;
    it.line_start     = ls;
    it.start_coverage = start;
    it.line_end       = le;
    return it;
  endfunction

  task automatic pause_input(int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Offer one pixel, hold it until the transfer, then maybe end the burst.
  task automatic offer_pixel(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 7));
    end
  endtask

  task automatic drain_pixels();
    pause_input(1);
    while (blend_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Alpha goes last: its write starts the ramp rebuild.
  task automatic set_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    drain_pixels();
    write_cfg(CFG_COLOR_RED, r);
    write_cfg(CFG_COLOR_GREEN, g);
    write_cfg(CFG_COLOR_BLUE, b);
    write_cfg(CFG_COLOR_ALPHA, a);
  endtask

  // Well-formed spans with random content, plus about one noise pixel in ten.
  task automatic run_spans(int unsigned n);
    int unsigned left;
    int unsigned span_len;
    int unsigned k;
    in_item_t    it;
    left = n;
    while (left != 0) begin
      span_len = $urandom_range(1, 40);
      if (span_len > left) span_len = left;
      for (k = 0; k < span_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = {$urandom, $urandom, 1'($urandom), $urandom, 1'($urandom)};
        end else begin
          it.dest_pixel = $urandom;
          it.line_start = (k == 0);
          it.line_end   = (k == span_len - 1);
          case ($urandom_range(0, 3))
            0:       it.start_coverage = $urandom;
            3:       it.start_coverage = {16'($urandom_range(250, 260)), 16'($urandom)};
            default: it.start_coverage = $urandom_range(0, 32'h0140_0000);
          endcase
          case ($urandom_range(0, 5))
            0:       it.coverage_delta = '0;
            4:       it.coverage_delta = (int'($urandom_range(0, 8)) - 4) * 65536;
            5:       it.coverage_delta = $urandom;
            default: it.coverage_delta = int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
          endcase
        end
        offer_pixel(it);
        left--;
      end
    end
  endtask

  initial begin
    blend_sb     = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_transfers = 0;
    cfg_writes   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset paint: black, opaque. Zero index, ramp ends, full fill, wrap both ways.
    offer_pixel(mk_item(32'hffff_ffff, 32'h0, 32'h0, 1'b1, 1'b0));
    offer_pixel(mk_item(32'hffff_ffff, 32'h0, 32'h0001_0000, 1'b0, 1'b0));
    offer_pixel(mk_item(32'h8080_8080, 32'h0, 32'h00fd_0000, 1'b0, 1'b0));
    offer_pixel(mk_item(32'h1234_5678, 32'h0, 32'h0001_0000, 1'b0, 1'b0));
    offer_pixel(mk_item(32'ha5a5_5a5a, 32'h0, 32'h7fff_ffff, 1'b0, 1'b0));
    offer_pixel(mk_item(32'h0000_0000, 32'h0, 32'h8000_0000, 1'b0, 1'b1));
    offer_pixel(mk_item(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 1'b1, 1'b0));
    offer_pixel(mk_item(32'h5a5a_a5a5, 32'h0, 32'hffff_0000, 1'b0, 1'b0));
    offer_pixel(mk_item(32'h0000_0000, 32'h0000_ffff, 32'h0, 1'b1, 1'b1));
    offer_pixel(mk_item(32'hffff_ffff, 32'h0080_8000, 32'h0, 1'b1, 1'b0));

    // Translucent: index masked to 8 bits; writes past the register list are dropped.
    set_paint(8'hff, 8'h00, 8'h80, 8'h80);
    write_cfg(CfgIdxPastEnd, 8'h3c);
    write_cfg(CfgIdxTop, 8'h3c);
    offer_pixel(mk_item(32'h0000_0000, 32'h0001_0000, 32'h0, 1'b1, 1'b0));
    offer_pixel(mk_item(32'hffff_ffff, 32'h01ff_0000, 32'h0, 1'b1, 1'b0));
    offer_pixel(mk_item(32'h8080_8080, 32'h0100_0000, 32'h0, 1'b1, 1'b0));
    offer_pixel(mk_item(32'h00ff_00ff, 32'h0, 32'h0080_0000, 1'b0, 1'b0));
    offer_pixel(mk_item(32'hffff_ffff, 32'hffff_ffff, 32'h0001_0001, 1'b1, 1'b1));

    set_paint(8'($urandom), 8'($urandom), 8'($urandom), OPAQUE_ALPHA);
    run_spans(30);
    hold_off_req = 1'b1;
    run_spans(90);
    set_paint(8'hff, 8'hff, 8'hff, 8'h00);
    run_spans(115);
    set_paint(8'h00, 8'h00, 8'h00, 8'hfe);
    run_spans(115);
    set_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'h01);
    run_spans(115);
    set_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'h80);
    run_spans(55);
    drain_pixels();
    run_spans(60);
    set_paint(8'h00, 8'hff, 8'h00, OPAQUE_ALPHA);
    run_spans(115);
    set_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_spans(115);
    set_paint(8'hff, 8'hff, 8'hff, OPAQUE_ALPHA);
    run_spans(115);
    drain_pixels();

    $display("Ran %0d pixel transfers over 10 paint settings, %0d results checked, %0d writes",
             in_transfers, blend_sb.pixels_checked, cfg_writes);
    if (blend_sb.mismatches == 0 && blend_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
